// ----- hdl/dioreg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dioreg_pkg: shared types and constants
// Byte lane decode record, register kind codes and I/O offsets.
// ----------------------------------------------------------------------------
package dioreg_pkg;

	localparam int OffW   = 10;
	localparam int Lanes  = 4;
	localparam int LaneW  = 2;

	// offsets within the I/O region
	localparam logic [OffW-1:0] OffDispcntHi = 10'h001;
	localparam logic [OffW-1:0] OffRsvdHi    = 10'h003;
	localparam logic [OffW-1:0] OffStatHi    = 10'h005;
	localparam logic [OffW-1:0] OffVcountLo  = 10'h006;
	localparam logic [OffW-1:0] OffVcountHi  = 10'h007;
	localparam logic [OffW-1:0] OffBgcntHi   = 10'h00F;
	localparam logic [OffW-1:0] OffScrollHi  = 10'h01F;
	localparam logic [OffW-1:0] OffImeLo     = 10'h208;
	localparam logic [OffW-1:0] OffImeHi     = 10'h209;
	localparam logic [OffW-1:0] OffImeRsvdLo = 10'h20A;
	localparam logic [OffW-1:0] OffImeRsvdHi = 10'h20B;

	// access size codes
	localparam logic [1:0] OpByte    = 2'd0;
	localparam logic [1:0] OpHalf    = 2'd1;
	localparam logic [1:0] OpWord    = 2'd2;
	localparam logic [1:0] OpWordAlt = 2'd3;  // spare code, handled as a word

	typedef enum logic [2:0] {
		KIND_DISPCNT,
		KIND_DISPSTAT,
		KIND_BGCNT,
		KIND_SCROLL,
		KIND_IME,
		KIND_IGNORE,
		KIND_UNMAPPED
	} kind_t;

	typedef struct packed {
		logic [OffW-1:0] offset;
		logic [7:0]      data;
		kind_t           kind;
		logic [2:0]      idx;
		logic            hi;
	} lane_t;

endpackage

// ----- hdl/dioreg_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dioreg_lane: byte lane decoder
// Forms the offset and data byte of one lane and decodes its target register.
// ----------------------------------------------------------------------------
module dioreg_lane
	import dioreg_pkg::*;
(
	input  logic [LaneW-1:0] lane_idx,
	input  logic [OffW-1:0]  io_offset,
	input  logic [31:0]      write_data,
	output lane_t            lane
);

	logic [OffW-1:0] off;

	assign off = io_offset + {{(OffW-LaneW){1'b0}}, lane_idx};

	always_comb begin
		lane.offset = off;
		lane.data   = write_data[8*lane_idx +: 8];
		lane.hi     = off[0];
		lane.idx    = 3'd0;
		if (off <= OffDispcntHi) begin
			lane.kind = KIND_DISPCNT;
		end else if (off <= OffRsvdHi || off == OffVcountLo || off == OffVcountHi) begin
			lane.kind = KIND_IGNORE;
		end else if (off <= OffStatHi) begin
			lane.kind = KIND_DISPSTAT;
		end else if (off <= OffBgcntHi) begin
			lane.kind = KIND_BGCNT;
			lane.idx  = {1'b0, off[2:1]};
		end else if (off <= OffScrollHi) begin
			lane.kind = KIND_SCROLL;
			lane.idx  = off[3:1];
		end else if (off == OffImeLo || off == OffImeHi) begin
			lane.kind = KIND_IME;
		end else if (off == OffImeRsvdLo || off == OffImeRsvdHi) begin
			lane.kind = KIND_IGNORE;
		end else begin
			lane.kind = KIND_UNMAPPED;
		end
	end

endmodule

// ----- hdl/dioreg_regfile.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dioreg_regfile: display register file
// Applies one decoded byte write per wr_en cycle, returns the packed halfword.
// ----------------------------------------------------------------------------
module dioreg_regfile
	import dioreg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  lane_t       lane,
	output logic [15:0] value,
	output logic        unmapped
);

	logic [15:0] dispcnt_q;
	logic [10:0] dispstat_q;     // [2:0] enables, [10:3] line compare
	logic [13:0] bgcnt_q [4];    // [13:6] high byte, [5:0] low bits 7:6,3:0
	logic [8:0]  scroll_q [8];
	logic        ime_q;

	logic [15:0] dispcnt_d;
	logic [10:0] dispstat_d;
	logic [13:0] bgcnt_d;
	logic [8:0]  scroll_d;
	logic        ime_d;
	logic [13:0] bg_cur;
	logic [8:0]  sc_cur;
	logic [7:0]  d;

	assign d      = lane.data;
	assign bg_cur = bgcnt_q[lane.idx[1:0]];
	assign sc_cur = scroll_q[lane.idx];

	always_comb begin
		dispcnt_d  = lane.hi ? {d, dispcnt_q[7:0]} : {dispcnt_q[15:8], d & 8'hF7};
		dispstat_d = lane.hi ? {d, dispstat_q[2:0]} : {dispstat_q[10:3], d[5:3]};
		if (!lane.hi)
			bgcnt_d = {bg_cur[13:6], d[7:6], d[3:0]};
		else if (lane.idx[1])
			bgcnt_d = {d, bg_cur[5:0]};
		else
			bgcnt_d = {d[7:6], bg_cur[11], d[4:0], bg_cur[5:0]};   // overflow kept
		scroll_d = lane.hi ? {d[0], sc_cur[7:0]} : {1'b0, d};
		ime_d    = lane.hi ? ime_q : d[0];
	end

	always_comb begin
		value    = 16'h0000;
		unmapped = 1'b0;
		case (lane.kind)
			KIND_DISPCNT:  value = dispcnt_d;
			KIND_DISPSTAT: value = {dispstat_d[10:3], 2'b00, dispstat_d[2:0], 3'b000};
			KIND_BGCNT:    value = {bgcnt_d[13:6], bgcnt_d[5:4], 2'b00, bgcnt_d[3:0]};
			KIND_SCROLL:   value = {7'd0, scroll_d};
			KIND_IME:      value = {15'd0, ime_d};
			KIND_UNMAPPED: unmapped = 1'b1;
			default:       value = 16'h0000;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dispcnt_q  <= '0;
			dispstat_q <= '0;
			ime_q      <= 1'b0;
			for (int i = 0; i < 4; i++) bgcnt_q[i] <= '0;
			for (int i = 0; i < 8; i++) scroll_q[i] <= '0;
		end else if (wr_en) begin
			case (lane.kind)
				KIND_DISPCNT:  dispcnt_q <= dispcnt_d;
				KIND_DISPSTAT: dispstat_q <= dispstat_d;
				KIND_BGCNT:    bgcnt_q[lane.idx[1:0]] <= bgcnt_d;
				KIND_SCROLL:   scroll_q[lane.idx] <= scroll_d;
				KIND_IME:      ime_q <= ime_d;
				default:       ;
			endcase
		end
	end

endmodule

// ----- hdl/display_io_register_write.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_io_register_write: display I/O register write port
// Splits a bus write into byte writes and updates the display registers.
// ----------------------------------------------------------------------------
// An accepted write item is split at once by four byte-lane decoders into
// byte writes at io_offset + 0..3 (wrapping within the 1 KiB region, low data
// byte first). The lane records are held, and the register file then applies
// one byte per cycle while the result side keeps up, each producing one
// result item with the byte's offset, the packed halfword after that write,
// an unmapped flag and a last marker. A byte access writes one lane, a
// halfword two and a word (or size code three) all four, through the
// register file's single write port, which serves one lane a cycle. A new
// write item is taken in the cycle after the last byte of the current one
// has moved into the result register, so back-to-back accesses leave a gap
// in the results even while the result side keeps up; while res_ready holds
// off a waiting result, the byte sequence stalls.
// Reserved and read-only bytes report zero; unknown offsets report unmapped.
// ----------------------------------------------------------------------------
module display_io_register_write
	import dioreg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [OffW-1:0]  io_offset,
	input  logic [1:0]       op,
	input  logic [31:0]      write_data,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [OffW-1:0]  byte_offset,
	output logic [15:0]      register_value,
	output logic             unmapped,
	output logic             last
);

	lane_t            lane_d [Lanes];
	lane_t            lanes_q [Lanes];
	lane_t            cur;
	logic             busy_q;
	logic [LaneW-1:0] k_q;
	logic [LaneW-1:0] last_idx_q;
	logic             res_valid_q;
	logic             accept;
	logic             step;
	logic             is_last;
	logic [15:0]      rf_value;
	logic             rf_unmapped;

	// byte lanes decode all bytes of the item side by side
	for (genvar g = 0; g < Lanes; g++) begin : g_lane
		dioreg_lane u_lane (
			.lane_idx   (LaneW'(g)),
			.io_offset  (io_offset),
			.write_data (write_data),
			.lane       (lane_d[g])
		);
	end

	assign wr_ready = !busy_q;
	assign accept   = wr_valid && wr_ready;
	assign step     = busy_q && (!res_valid_q || res_ready);
	assign cur      = lanes_q[k_q];
	assign is_last  = (k_q == last_idx_q);

	dioreg_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (step),
		.lane     (cur),
		.value    (rf_value),
		.unmapped (rf_unmapped)
	);

	// sequencer over the held lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			last_idx_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				case (op)
					OpByte:  last_idx_q <= LaneW'(0);
					OpHalf:  last_idx_q <= LaneW'(1);
					default: last_idx_q <= LaneW'(Lanes - 1);
				endcase
			end else if (step) begin
				if (is_last)
					busy_q <= 1'b0;
				else
					k_q <= k_q + LaneW'(1);
			end
			if (step)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// lane records and result register (payload only)
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < Lanes; i++) lanes_q[i] <= lane_d[i];
		end
		if (step) begin
			byte_offset    <= cur.offset;
			register_value <= rf_value;
			unmapped       <= rf_unmapped;
			last           <= is_last;
		end
	end

	assign res_valid = res_valid_q;

endmodule
